// File: src/remote_destination_classifier_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the remote destination classifier
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef REMOTE_DESTINATION_CLASSIFIER_CORE_ASSERT_SVH
`define REMOTE_DESTINATION_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define RDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Types and codes shared by the classifier cells and the top level.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int RDC_INDEX_W = 4;
    localparam int RDC_FIELD_SLOTS = 2 ** RDC_INDEX_W;

    localparam logic [1:0] REQ_LOOKUP    = 2'd0;
    localparam logic [1:0] REQ_WR_SUBNET = 2'd1;
    localparam logic [1:0] REQ_WR_HOST   = 2'd2;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [31:0]            dest_addr;
        logic [RDC_INDEX_W-1:0] entry_index;
        logic                   entry_enable;
        logic [31:0]            entry_mask;
        logic [31:0]            entry_address;
        logic                   entry_ignore;
    } rdc_req_t;

    typedef struct packed {
        logic                   subnet_hit;
        logic [RDC_INDEX_W-1:0] subnet_index;
        logic                   host_hit;
        logic [RDC_INDEX_W-1:0] host_index;
        logic                   bypass;
    } rdc_rsp_t;

    // request plus the search state carried from cell to cell
    typedef struct packed {
        rdc_req_t               req;
        logic                   s_found;
        logic [RDC_INDEX_W-1:0] s_idx;
        logic                   h_done;
        logic                   h_hit;
        logic [RDC_INDEX_W-1:0] h_idx;
    } rdc_beat_t;

endpackage

// File: src/rdc_cell.sv
// ----------------------------------------------------------------------------
// rdc_cell
// One table slot of both tables. Applies a write aimed at its slot, or
// checks a lookup against its entries, and registers the beat onward.
// ----------------------------------------------------------------------------
module rdc_cell
    import rdc_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      in_valid,
    input  rdc_beat_t in_beat,
    output logic      out_valid,
    output rdc_beat_t out_beat
);

    // slots past the 4-bit index field can never be written
    localparam bit SLOT_REACHABLE = (CELL_IDX < RDC_FIELD_SLOTS);
    localparam logic [RDC_INDEX_W-1:0] CELL_TAG = RDC_INDEX_W'(CELL_IDX % RDC_FIELD_SLOTS);

    logic        sub_valid_reg;
    logic        sub_valid_next;
    logic [31:0] sub_mask_reg;
    logic [31:0] sub_net_reg;
    logic        host_valid_reg;
    logic        host_valid_next;
    logic [31:0] host_addr_reg;
    logic        host_ign_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    rdc_beat_t   out_beat_reg;
    rdc_beat_t   out_beat_next;

    logic        take;
    logic        slot_sel;
    logic        wr_sub;
    logic        wr_host;

    always_comb
    begin
        take     = advance && in_valid;
        slot_sel = SLOT_REACHABLE && (in_beat.req.entry_index == CELL_TAG);
        wr_sub   = take && slot_sel && (in_beat.req.req_type == REQ_WR_SUBNET);
        wr_host  = take && slot_sel && (in_beat.req.req_type == REQ_WR_HOST);

        sub_valid_next  = wr_sub ? in_beat.req.entry_enable : sub_valid_reg;
        host_valid_next = wr_host ? in_beat.req.entry_enable : host_valid_reg;
        out_valid_next  = advance ? in_valid : out_valid_reg;

        out_beat_next = in_beat;
        if (in_beat.req.req_type == REQ_LOOKUP)
        begin
            if (!in_beat.s_found && sub_valid_reg &&
                ((in_beat.req.dest_addr & sub_mask_reg) == sub_net_reg))
            begin
                out_beat_next.s_found = 1'b1;
                out_beat_next.s_idx   = CELL_TAG;
            end
            // first address match ends the host search, ignored or not
            if (!in_beat.h_done && host_valid_reg &&
                (host_addr_reg == in_beat.req.dest_addr))
            begin
                out_beat_next.h_done = 1'b1;
                out_beat_next.h_hit  = !host_ign_reg;
                out_beat_next.h_idx  = host_ign_reg ? '0 : CELL_TAG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_valid_reg  <= 1'b0;
            host_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            sub_valid_reg  <= sub_valid_next;
            host_valid_reg <= host_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_sub)
        begin
            sub_mask_reg <= in_beat.req.entry_mask;
            sub_net_reg  <= in_beat.req.entry_address;
        end
        if (wr_host)
        begin
            host_addr_reg <= in_beat.req.entry_address;
            host_ign_reg  <= in_beat.req.entry_ignore;
        end
        if (advance)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

// File: src/remote_destination_classifier_core.sv
// ----------------------------------------------------------------------------
// remote_destination_classifier_core
// Remote subnet and remote host match tables, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Every request beat (lookup, subnet write or host write) walks a chain of
// TABLE_DEPTH cells, one cell per slot, one cell per cycle unless the chain
// holds. A new beat is taken every cycle while req_ready is high, and the
// responses come out in request order. Writes land in their slot as they
// pass, so a lookup always sees every earlier write.
// When a response is not taken the whole chain holds and req_ready drops.
// With check_enable cleared, lookups return bypass with both indices zero.
// ----------------------------------------------------------------------------
module remote_destination_classifier_core
    import rdc_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  rdc_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output rdc_rsp_t rsp,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

`include "remote_destination_classifier_core_assert.svh"

    logic      check_enable_reg;
    logic      check_enable_next;
    logic      advance;
    logic      is_lookup;
    rdc_beat_t head_beat;
    logic      chain_valid [0:TABLE_DEPTH];
    rdc_beat_t chain_beat  [0:TABLE_DEPTH];

    assign advance   = !chain_valid[TABLE_DEPTH] || rsp_ready;
    assign req_ready = advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        head_beat         = '0;
        head_beat.req     = req;
        check_enable_next = (cfg_valid && cfg_ready) ? cfg_data : check_enable_reg;
    end

    assign chain_valid[0] = req_valid;
    assign chain_beat[0]  = head_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_enable_reg <= 1'b1;
        end
        else
        begin
            check_enable_reg <= check_enable_next;
        end
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        rdc_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_beat   (chain_beat[i]),
            .out_valid (chain_valid[i+1]),
            .out_beat  (chain_beat[i+1])
        );
    end

    always_comb
    begin
        is_lookup = (chain_beat[TABLE_DEPTH].req.req_type == REQ_LOOKUP);
        rsp       = '0;
        if (is_lookup)
        begin
            rsp.subnet_hit = chain_beat[TABLE_DEPTH].s_found;
            rsp.host_hit   = chain_beat[TABLE_DEPTH].h_hit;
            rsp.bypass     = !check_enable_reg;
            if (check_enable_reg)
            begin
                rsp.subnet_index = chain_beat[TABLE_DEPTH].s_idx;
                rsp.host_index   = chain_beat[TABLE_DEPTH].h_idx;
            end
        end
    end

    assign rsp_valid = chain_valid[TABLE_DEPTH];

    `RDC_ASSERT_NOW(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready,
        "request taken while the response is stalled")
    `RDC_ASSERT_NOW(a_bypass_zero_idx, rsp_valid && rsp.bypass,
        rsp.subnet_index == '0 && rsp.host_index == '0 && !check_enable_reg,
        "bypass response carries an index")
    `RDC_ASSERT_NOW(a_subnet_miss_idx, rsp_valid && !rsp.subnet_hit,
        rsp.subnet_index == '0, "subnet miss with nonzero index")
    `RDC_ASSERT_NOW(a_host_miss_idx, rsp_valid && !rsp.host_hit,
        rsp.host_index == '0, "host miss with nonzero index")
    `RDC_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready,
        rsp_valid && $stable(chain_beat[TABLE_DEPTH]),
        "chain moved while the response is stalled")

endmodule
